// File: hw/rtl/sac_pkg.sv
// Shared types and constants of the set-associative LRU cache model.
// No dependencies; every other file of the block but sac_ram imports this package.
package sac_pkg;

  localparam int ADDR_W = 64;
  localparam int TAG_W  = 63;
  localparam int CNT_W  = 32;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SET_BITS   = 2'd0,
    CFG_WAYS       = 2'd1,
    CFG_BLOCK_BITS = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_STORE  = 2'd1,
    OP_MODIFY = 2'd2
  } opcode_t;

  localparam logic [2:0] SET_BITS_RST   = 3'd4;
  localparam logic [3:0] WAYS_RST       = 4'd1;
  localparam logic [5:0] BLOCK_BITS_RST = 6'd4;

endpackage

// File: hw/rtl/sac_if.sv
// Valid/ready channel interfaces for access beats and result beats.
// Depends on sac_pkg for field widths.
interface sac_in_if import sac_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        opcode;
  logic [ADDR_W-1:0] address;

  modport source (output valid, output opcode, output address, input ready);
  modport sink   (input valid, input opcode, input address, output ready);
endinterface

interface sac_out_if import sac_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [1:0]       hits_now;
  logic             missed;
  logic             evicted;
  logic [CNT_W-1:0] hit_total;
  logic [CNT_W-1:0] miss_total;
  logic [CNT_W-1:0] evict_total;

  modport source (output valid, output hits_now, output missed, output evicted,
                  output hit_total, output miss_total, output evict_total,
                  input ready);
  modport sink   (input valid, input hits_now, input missed, input evicted,
                  input hit_total, input miss_total, input evict_total,
                  output ready);
endinterface

// File: hw/rtl/sac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sac_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/sac_row_upd.sv
// Recency update of one set row: promote the target way, age the valid ways ranked below it.
// Depends on sac_pkg.
module sac_row_upd import sac_pkg::*; #(
  parameter int WAYS = 8,
  localparam int RW = (WAYS > 1) ? $clog2(WAYS) : 1
) (
  input  logic [WAYS-1:0]         vld_i,
  input  logic [WAYS-1:0][RW-1:0] rank_i,
  input  logic [RW-1:0]           tgt,
  input  logic                    fresh,
  output logic [WAYS-1:0]         vld_o,
  output logic [WAYS-1:0][RW-1:0] rank_o
);

  logic [RW:0] old_rank;

  assign old_rank = fresh ? (RW+1)'(WAYS) : {1'b0, rank_i[tgt]};

  always_comb begin
    for (int i = 0; i < WAYS; i++) begin
      if (RW'(i) == tgt) begin
        vld_o[i]  = 1'b1;
        rank_o[i] = '0;
      end else begin
        vld_o[i] = vld_i[i];
        if (vld_i[i] && ({1'b0, rank_i[i]} < old_rank)) begin
          rank_o[i] = rank_i[i] + RW'(1);
        end else begin
          rank_o[i] = rank_i[i];
        end
      end
    end
  end

endmodule

// File: hw/rtl/set_assoc_lru_cache_sim.sv
// Set-associative LRU cache model: one access beat in, one result beat out.
// An access passes DECODE, PREP, SEARCH (1..ways_in_use ways, stopping at a hit) and
// UPDATE; an invalid opcode skips to DONE. One access at a time; next accept after DONE.
// The sequencer compares one stored tag per cycle through one tag RAM read port.
// Reset: synchronous, active low; a clearing pass then zeroes MAX_SETS set rows,
// one per cycle, with no access accepted. Depends on sac_pkg, sac_if, sac_ram,
// sac_row_upd.
module set_assoc_lru_cache_sim import sac_pkg::*; #(
  parameter int MAX_SETS = 64,
  parameter int MAX_WAYS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  sac_in_if.sink                in_bus,
  sac_out_if.source             out_bus,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SW    = $clog2(MAX_SETS);
  localparam int MSB   = $clog2(MAX_SETS + 1) - 1;
  localparam int WW    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WCW   = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * (1 + WW);
  localparam int LINES = MAX_SETS * MAX_WAYS;
  localparam int TAW   = $clog2(LINES);

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_DECODE, ST_PREP, ST_SEARCH, ST_UPDATE, ST_DONE
  } state_t;

  function automatic logic [CNT_W-1:0] sat_add(logic [CNT_W-1:0] c, logic [1:0] n);
    logic [CNT_W:0] s;
    s = {1'b0, c} + (CNT_W+1)'(n);
    return s[CNT_W] ? '1 : s[CNT_W-1:0];
  endfunction

  state_t st_r, st_nxt;
  logic [SW-1:0]     clr_r, clr_nxt;
  logic [2:0]        set_bits_r, set_bits_nxt;
  logic [3:0]        ways_cfg_r, ways_cfg_nxt;
  logic [5:0]        block_bits_r, block_bits_nxt;
  logic [1:0]        op_r, op_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [SW-1:0]     set_r, set_nxt;
  logic [TAG_W-1:0]  tag_r, tag_nxt;
  logic [WW-1:0]     way_r, way_nxt;
  logic              inv_seen_r, inv_seen_nxt;
  logic [WW-1:0]     first_inv_r, first_inv_nxt;
  logic [WW-1:0]     victim_r, victim_nxt;
  logic [WW-1:0]     vrank_r, vrank_nxt;
  logic              hit_r, hit_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  miss_cnt_r, miss_cnt_nxt;
  logic [CNT_W-1:0]  evict_cnt_r, evict_cnt_nxt;
  logic [1:0]        res_hits_r, res_hits_nxt;
  logic              res_miss_r, res_miss_nxt;
  logic              res_ev_r, res_ev_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        o_hits_r, o_hits_nxt;
  logic              o_miss_r, o_miss_nxt;
  logic              o_ev_r, o_ev_nxt;
  logic [CNT_W-1:0]  o_hit_tot_r, o_hit_tot_nxt;
  logic [CNT_W-1:0]  o_miss_tot_r, o_miss_tot_nxt;
  logic [CNT_W-1:0]  o_ev_tot_r, o_ev_tot_nxt;

  logic [2:0]        sb_eff;
  logic [WCW-1:0]    ways_eff;
  logic [ADDR_W-1:0] set_shift;
  logic [ADDR_W-1:0] tag_shift;
  logic [SW-1:0]     set_mask;

  logic              row_we;
  logic [SW-1:0]     row_waddr;
  logic [ROW_W-1:0]  row_wdata;
  logic              row_re;
  logic [ROW_W-1:0]  row_rdata;
  logic [MAX_WAYS-1:0]         row_vld;
  logic [MAX_WAYS-1:0][WW-1:0] row_rank;
  logic [MAX_WAYS-1:0]         new_vld;
  logic [MAX_WAYS-1:0][WW-1:0] new_rank;

  logic              tag_we;
  logic [TAW-1:0]    tag_waddr;
  logic              tag_re;
  logic [TAW-1:0]    tag_raddr;
  logic [TAG_W-1:0]  tag_rdata;
  logic [WW-1:0]     rd_way;

  logic              cur_vld;
  logic [WW-1:0]     cur_rank;
  logic              match;
  logic              last_way;
  logic [WW-1:0]     tgt_way;
  logic              fresh;
  logic              out_free;

  // effective geometry
  always_comb begin
    sb_eff = (set_bits_r == 3'd0) ? 3'd1 : set_bits_r;
    if (MSB < 7 && int'(sb_eff) > MSB) begin
      sb_eff = 3'(MSB);
    end
    if (ways_cfg_r == 4'd0) begin
      ways_eff = WCW'(1);
    end else if (int'(ways_cfg_r) > MAX_WAYS) begin
      ways_eff = WCW'(MAX_WAYS);
    end else begin
      ways_eff = WCW'(ways_cfg_r);
    end
  end

  assign set_shift = addr_r >> block_bits_r;
  assign tag_shift = addr_r >> ({1'b0, block_bits_r} + 7'(sb_eff));
  assign set_mask  = ~({SW{1'b1}} << sb_eff);

  assign row_vld  = row_rdata[ROW_W-1 -: MAX_WAYS];
  assign row_rank = row_rdata[MAX_WAYS*WW-1:0];
  assign cur_vld  = row_vld[way_r];
  assign cur_rank = row_rank[way_r];
  assign match    = cur_vld && (tag_rdata == tag_r);
  assign last_way = ((WCW+1)'(way_r) + (WCW+1)'(1)) == (WCW+1)'(ways_eff);

  assign fresh   = !hit_r && inv_seen_r;
  assign tgt_way = hit_r ? way_r : (inv_seen_r ? first_inv_r : victim_r);

  sac_row_upd #(.WAYS(MAX_WAYS)) u_row_upd (
    .vld_i  (row_vld),
    .rank_i (row_rank),
    .tgt    (tgt_way),
    .fresh  (fresh),
    .vld_o  (new_vld),
    .rank_o (new_rank)
  );

  always_comb begin
    row_we    = (st_r == ST_CLEAR) || (st_r == ST_UPDATE);
    row_waddr = (st_r == ST_CLEAR) ? clr_r : set_r;
    row_wdata = (st_r == ST_CLEAR) ? '0 : {new_vld, new_rank};
    row_re    = (st_r == ST_PREP);
  end

  always_comb begin
    rd_way    = (st_r == ST_PREP) ? '0 : way_r + WW'(1);
    tag_re    = (st_r == ST_PREP) || ((st_r == ST_SEARCH) && !match && !last_way);
    tag_raddr = TAW'(set_r) * TAW'(MAX_WAYS) + TAW'(rd_way);
    tag_we    = (st_r == ST_UPDATE) && !hit_r;
    tag_waddr = TAW'(set_r) * TAW'(MAX_WAYS) + TAW'(tgt_way);
  end

  sac_ram #(.WIDTH(ROW_W), .DEPTH(MAX_SETS)) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (row_waddr),
    .wdata (row_wdata),
    .re    (row_re),
    .raddr (set_r),
    .rdata (row_rdata)
  );

  sac_ram #(.WIDTH(TAG_W), .DEPTH(LINES)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (tag_waddr),
    .wdata (tag_r),
    .re    (tag_re),
    .raddr (tag_raddr),
    .rdata (tag_rdata)
  );

  assign out_free = !out_valid_r || out_bus.ready;

  always_comb begin
    st_nxt         = st_r;
    clr_nxt        = clr_r;
    set_bits_nxt   = set_bits_r;
    ways_cfg_nxt   = ways_cfg_r;
    block_bits_nxt = block_bits_r;
    op_nxt         = op_r;
    addr_nxt       = addr_r;
    set_nxt        = set_r;
    tag_nxt        = tag_r;
    way_nxt        = way_r;
    inv_seen_nxt   = inv_seen_r;
    first_inv_nxt  = first_inv_r;
    victim_nxt     = victim_r;
    vrank_nxt      = vrank_r;
    hit_nxt        = hit_r;
    hit_cnt_nxt    = hit_cnt_r;
    miss_cnt_nxt   = miss_cnt_r;
    evict_cnt_nxt  = evict_cnt_r;
    res_hits_nxt   = res_hits_r;
    res_miss_nxt   = res_miss_r;
    res_ev_nxt     = res_ev_r;
    out_valid_nxt  = out_valid_r && !out_bus.ready;
    o_hits_nxt     = o_hits_r;
    o_miss_nxt     = o_miss_r;
    o_ev_nxt       = o_ev_r;
    o_hit_tot_nxt  = o_hit_tot_r;
    o_miss_tot_nxt = o_miss_tot_r;
    o_ev_tot_nxt   = o_ev_tot_r;

    if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SET_BITS:   set_bits_nxt   = cfg_wdata[2:0];
        CFG_WAYS:       ways_cfg_nxt   = cfg_wdata[3:0];
        CFG_BLOCK_BITS: block_bits_nxt = cfg_wdata;
        default: ;
      endcase
    end

    unique case (st_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + SW'(1);
        if (int'(clr_r) == MAX_SETS - 1) begin
          st_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_bus.valid) begin
          op_nxt   = in_bus.opcode;
          addr_nxt = in_bus.address;
          st_nxt   = ST_DECODE;
        end
      end
      ST_DECODE: begin
        set_nxt = set_shift[SW-1:0] & set_mask;
        tag_nxt = tag_shift[TAG_W-1:0];
        case (op_r) inside
          OP_LOAD, OP_STORE, OP_MODIFY: st_nxt = ST_PREP;
          default: begin
            res_hits_nxt = 2'd0;
            res_miss_nxt = 1'b0;
            res_ev_nxt   = 1'b0;
            st_nxt       = ST_DONE;
          end
        endcase
      end
      ST_PREP: begin
        way_nxt      = '0;
        inv_seen_nxt = 1'b0;
        st_nxt       = ST_SEARCH;
      end
      ST_SEARCH: begin
        if (!cur_vld && !inv_seen_r) begin
          inv_seen_nxt  = 1'b1;
          first_inv_nxt = way_r;
        end
        if (way_r == '0 || cur_rank > vrank_r) begin
          victim_nxt = way_r;
          vrank_nxt  = cur_rank;
        end
        if (match) begin
          hit_nxt = 1'b1;
          st_nxt  = ST_UPDATE;
        end else if (last_way) begin
          hit_nxt = 1'b0;
          st_nxt  = ST_UPDATE;
        end else begin
          way_nxt = way_r + WW'(1);
        end
      end
      ST_UPDATE: begin
        res_hits_nxt  = {1'b0, hit_r} + {1'b0, op_r == OP_MODIFY};
        res_miss_nxt  = !hit_r;
        res_ev_nxt    = !hit_r && !inv_seen_r;
        hit_cnt_nxt   = sat_add(hit_cnt_r, {1'b0, hit_r} + {1'b0, op_r == OP_MODIFY});
        miss_cnt_nxt  = sat_add(miss_cnt_r, {1'b0, !hit_r});
        evict_cnt_nxt = sat_add(evict_cnt_r, {1'b0, !hit_r && !inv_seen_r});
        st_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_hits_nxt     = res_hits_r;
          o_miss_nxt     = res_miss_r;
          o_ev_nxt       = res_ev_r;
          o_hit_tot_nxt  = hit_cnt_r;
          o_miss_tot_nxt = miss_cnt_r;
          o_ev_tot_nxt   = evict_cnt_r;
          st_nxt         = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_CLEAR;
      clr_r        <= '0;
      set_bits_r   <= SET_BITS_RST;
      ways_cfg_r   <= WAYS_RST;
      block_bits_r <= BLOCK_BITS_RST;
      hit_cnt_r    <= '0;
      miss_cnt_r   <= '0;
      evict_cnt_r  <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      st_r         <= st_nxt;
      clr_r        <= clr_nxt;
      set_bits_r   <= set_bits_nxt;
      ways_cfg_r   <= ways_cfg_nxt;
      block_bits_r <= block_bits_nxt;
      hit_cnt_r    <= hit_cnt_nxt;
      miss_cnt_r   <= miss_cnt_nxt;
      evict_cnt_r  <= evict_cnt_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    addr_r       <= addr_nxt;
    set_r        <= set_nxt;
    tag_r        <= tag_nxt;
    way_r        <= way_nxt;
    inv_seen_r   <= inv_seen_nxt;
    first_inv_r  <= first_inv_nxt;
    victim_r     <= victim_nxt;
    vrank_r      <= vrank_nxt;
    hit_r        <= hit_nxt;
    res_hits_r   <= res_hits_nxt;
    res_miss_r   <= res_miss_nxt;
    res_ev_r     <= res_ev_nxt;
    o_hits_r     <= o_hits_nxt;
    o_miss_r     <= o_miss_nxt;
    o_ev_r       <= o_ev_nxt;
    o_hit_tot_r  <= o_hit_tot_nxt;
    o_miss_tot_r <= o_miss_tot_nxt;
    o_ev_tot_r   <= o_ev_tot_nxt;
  end

  assign in_bus.ready        = (st_r == ST_IDLE);
  assign out_bus.valid       = out_valid_r;
  assign out_bus.hits_now    = o_hits_r;
  assign out_bus.missed      = o_miss_r;
  assign out_bus.evicted     = o_ev_r;
  assign out_bus.hit_total   = o_hit_tot_r;
  assign out_bus.miss_total  = o_miss_tot_r;
  assign out_bus.evict_total = o_ev_tot_r;

  a_evict_needs_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.evicted |-> out_bus.missed)
    else $error("eviction reported without a miss");

  a_search_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_SEARCH |-> (WCW+1)'(way_r) < (WCW+1)'(ways_eff))
    else $error("search ran past the ways in use");

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_CLEAR |-> !in_bus.ready)
    else $error("access accepted during clearing pass");

  a_hit_total_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> hit_cnt_r >= $past(hit_cnt_r))
    else $error("hit total decreased");

endmodule

// File: sim/tb_top.sv
// Testbench for set_assoc_lru_cache_sim: drives load/store/modify and invalid-opcode beats
// under several cache geometries and checks every result beat against an in-bench LRU
// cache predictor. Depends on sac_pkg, sac_if and the set_assoc_lru_cache_sim RTL.
module tb_top;
  import sac_pkg::*;

  localparam int MAX_SETS     = 64;
  localparam int MAX_WAYS     = 8;
  localparam int SET_BITS_MAX = $clog2(MAX_SETS);
  localparam int TAG_POOL     = MAX_WAYS + 3;
  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int SETTLE_CYCLES = 24;
  localparam int MAX_PRINTS   = 50;

  localparam logic [1:0]           OP_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_PATTERN} rx_mode_t;

  typedef struct packed {
    logic [1:0]       hits_now;
    logic             missed;
    logic             evicted;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] evict_total;
  } access_result_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  sac_in_if  in_bus();
  sac_out_if out_bus();

  set_assoc_lru_cache_sim #(.MAX_SETS(MAX_SETS), .MAX_WAYS(MAX_WAYS)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_bus    (in_bus),
    .out_bus   (out_bus),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  logic             line_valid [MAX_SETS][MAX_WAYS];
  logic [TAG_W-1:0] line_tag   [MAX_SETS][MAX_WAYS];
  logic [2:0]       line_rank  [MAX_SETS][MAX_WAYS];
  logic [CNT_W-1:0] hit_cnt;
  logic [CNT_W-1:0] miss_cnt;
  logic [CNT_W-1:0] evict_cnt;
  logic [2:0]       cfg_set_bits   = SET_BITS_RST;
  logic [3:0]       cfg_ways       = WAYS_RST;
  logic [5:0]       cfg_block_bits = BLOCK_BITS_RST;

  access_result_t   pending_results [$];
  logic [ADDR_W-1:0] tag_pool [TAG_POOL];
  int               err_count;
  int               cycle_count;
  int               burst_left;
  rx_mode_t         rx_mode;
  int               rx_left;
  logic [7:0]       rx_pattern = 8'b1011_0010;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(40, 300);
    end
    rx_left--;
    case (rx_mode)
      RX_OPEN:   out_bus.ready = 1'b1;
      RX_COIN:   out_bus.ready = $urandom_range(0, 1);
      RX_SPARSE: out_bus.ready = ($urandom_range(0, 3) == 0);
      default: begin
        out_bus.ready = rx_pattern[0];
        rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
      end
    endcase
  end

  task automatic report(string msg);
    err_count++;
    if (err_count <= MAX_PRINTS) $display("ERROR at %0t: %s", $time, msg);
  endtask

  function automatic int eff_set_bits();
    int n;
    n = cfg_set_bits;
    if (n < 1) n = 1;
    if (n > SET_BITS_MAX) n = SET_BITS_MAX;
    return n;
  endfunction

  function automatic int eff_ways();
    int n;
    n = cfg_ways;
    if (n < 1) n = 1;
    if (n > MAX_WAYS) n = MAX_WAYS;
    return n;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c, int n);
    logic [CNT_W:0] sum;
    sum = c + n;
    return sum[CNT_W] ? '1 : sum[CNT_W-1:0];
  endfunction

  // make way w the most recent; a fresh line ages every other valid way
  function automatic void promote_way(int s, int w, bit fresh);
    int old_rank;
    old_rank = fresh ? MAX_WAYS : line_rank[s][w];
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (i != w && line_valid[s][i] && line_rank[s][i] < old_rank)
        line_rank[s][i] = line_rank[s][i] + 3'd1;
    end
    line_rank[s][w] = '0;
  endfunction

  function automatic access_result_t cache_lookup(logic [1:0] op, logic [ADDR_W-1:0] addr);
    access_result_t r;
    int sb, ways, shift, set_idx, hit_way, free_way, victim;
    logic [TAG_W-1:0] tag;
    r = '0;
    if (op != OP_NONE) begin
      sb      = eff_set_bits();
      ways    = eff_ways();
      shift   = cfg_block_bits + sb;
      set_idx = int'((addr >> cfg_block_bits) & ((64'd1 << sb) - 64'd1));
      tag     = TAG_W'(addr >> shift);
      hit_way  = -1;
      free_way = -1;
      for (int i = 0; i < ways; i++) begin
        if (hit_way < 0 && line_valid[set_idx][i] && line_tag[set_idx][i] == tag) hit_way = i;
        if (free_way < 0 && !line_valid[set_idx][i]) free_way = i;
      end
      if (hit_way >= 0) begin
        promote_way(set_idx, hit_way, 1'b0);
        r.hits_now = 2'd1;
      end else if (free_way >= 0) begin
        promote_way(set_idx, free_way, 1'b1);
        line_valid[set_idx][free_way] = 1'b1;
        line_tag[set_idx][free_way]   = tag;
        r.missed = 1'b1;
      end else begin
        victim = 0;
        for (int i = 1; i < ways; i++) begin
          if (line_rank[set_idx][i] > line_rank[set_idx][victim]) victim = i;
        end
        promote_way(set_idx, victim, 1'b0);
        line_tag[set_idx][victim] = tag;
        r.missed  = 1'b1;
        r.evicted = 1'b1;
      end
      if (op == OP_MODIFY) r.hits_now = r.hits_now + 2'd1;
      hit_cnt   = sat_inc(hit_cnt, r.hits_now);
      miss_cnt  = sat_inc(miss_cnt, r.missed);
      evict_cnt = sat_inc(evict_cnt, r.evicted);
    end
    r.hit_total   = hit_cnt;
    r.miss_total  = miss_cnt;
    r.evict_total = evict_cnt;
    return r;
  endfunction

  always @(posedge clk) begin
    access_result_t got, want;
    if (rst_n) begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_SET_BITS:   cfg_set_bits   = cfg_wdata[2:0];
          CFG_WAYS:       cfg_ways       = cfg_wdata[3:0];
          CFG_BLOCK_BITS: cfg_block_bits = cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (in_bus.valid && in_bus.ready)
        pending_results.push_back(cache_lookup(in_bus.opcode, in_bus.address));
      if (out_bus.valid && out_bus.ready) begin
        got = {out_bus.hits_now, out_bus.missed, out_bus.evicted,
               out_bus.hit_total, out_bus.miss_total, out_bus.evict_total};
        if (pending_results.size() == 0) begin
          report("result beat with no access pending");
        end else begin
          want = pending_results.pop_front();
          if (got.hits_now !== want.hits_now)
            report($sformatf("hits_now %0d, want %0d", got.hits_now, want.hits_now));
          if (got.missed !== want.missed)
            report($sformatf("missed %0b, want %0b", got.missed, want.missed));
          if (got.evicted !== want.evicted)
            report($sformatf("evicted %0b, want %0b", got.evicted, want.evicted));
          if (got.hit_total !== want.hit_total)
            report($sformatf("hit_total %0d, want %0d", got.hit_total, want.hit_total));
          if (got.miss_total !== want.miss_total)
            report($sformatf("miss_total %0d, want %0d", got.miss_total, want.miss_total));
          if (got.evict_total !== want.evict_total)
            report($sformatf("evict_total %0d, want %0d", got.evict_total, want.evict_total));
        end
      end
    end
  end

  task automatic send_access(logic [1:0] op, logic [ADDR_W-1:0] addr);
    int gap;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_bus.valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_bus.valid   = 1'b1;
    in_bus.opcode  = op;
    in_bus.address = addr;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_geometry(logic [5:0] sb, logic [5:0] ways, logic [5:0] bb);
    wait_results_drained();
    write_cfg(CFG_SET_BITS, sb);
    write_cfg(CFG_WAYS, ways);
    write_cfg(CFG_BLOCK_BITS, bb);
  endtask

  function automatic logic [1:0] pick_opcode();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return OP_NONE;
    if (r < 8) return OP_LOAD;
    if (r < 14) return OP_STORE;
    return OP_MODIFY;
  endfunction

  // mostly addresses built from a small tag pool over a few sets, so lines get reused
  function automatic logic [ADDR_W-1:0] pick_address();
    logic [ADDR_W-1:0] raw, set_part;
    int sb;
    raw = {$urandom, $urandom};
    if ($urandom_range(0, 9) < 3) return raw;
    sb = eff_set_bits();
    set_part = ($urandom_range(0, 4) == 0) ? 64'($urandom) : 64'($urandom_range(0, 3));
    set_part = set_part & ((64'd1 << sb) - 64'd1);
    return (tag_pool[$urandom_range(0, eff_ways() + 2)] << (cfg_block_bits + sb))
         | (set_part << cfg_block_bits)
         | (raw & ((64'd1 << cfg_block_bits) - 64'd1));
  endfunction

  task automatic run_random_items(int count);
    for (int i = 0; i < TAG_POOL; i++)
      tag_pool[i] = (i < 4) ? 64'(i) : {$urandom, $urandom};
    for (int i = 0; i < count; i++) begin
      if (i == count / 2) wait_results_drained();
      send_access(pick_opcode(), pick_address());
    end
  endtask

  // reset geometry: 16 sets, direct mapped, 16-byte blocks
  task automatic test_reset_defaults();
    send_access(OP_LOAD,   64'h0);
    send_access(OP_LOAD,   64'hF);
    send_access(OP_STORE,  64'h8);
    send_access(OP_MODIFY, 64'h10);
    send_access(OP_MODIFY, 64'h1F);
    send_access(OP_LOAD,   64'h100);
    send_access(OP_STORE,  64'h0);
    send_access(OP_NONE,   64'h0);
    send_access(OP_LOAD,   '1);
    send_access(OP_STORE,  '1);
    send_access(OP_MODIFY, 64'h7FFF_FFFF_FFFF_FFFF);
    send_access(OP_LOAD,   64'h0000_0100_0000_00F0);
    send_access(OP_LOAD,   64'h0000_0000_0000_00F0);
    send_access(OP_LOAD,   64'h0000_0100_0000_00F0);
    send_access(OP_NONE,   '1);
    send_access(OP_LOAD,   64'h8000_0000_0000_0000);
    send_access(OP_MODIFY, 64'h8000_0000_0000_0000);
  endtask

  // shrink the ways so one tag lands twice in a set, then grow them back
  task automatic test_way_resize();
    set_geometry(6'd1, 6'd2, 6'd1);
    send_access(OP_LOAD,   64'h14);
    send_access(OP_LOAD,   64'h18);
    set_geometry(6'd1, 6'd1, 6'd1);
    send_access(OP_LOAD,   64'h1C);
    send_access(OP_STORE,  64'h18);
    set_geometry(6'd1, 6'd2, 6'd1);
    send_access(OP_LOAD,   64'h18);
    send_access(OP_LOAD,   64'h14);
    send_access(OP_MODIFY, 64'h18);
    send_access(OP_STORE,  64'h1C);
    set_geometry(6'd1, 6'd8, 6'd1);
    for (int i = 0; i < 10; i++) send_access(OP_LOAD, 64'((i + 5) << 2));
    send_access(OP_LOAD,   64'h18);
    set_geometry(6'd1, 6'd3, 6'd1);
    send_access(OP_LOAD,   64'h100);
    send_access(OP_LOAD,   64'h104);
    send_access(OP_LOAD,   64'h14);
  endtask

  task automatic test_geometry_extremes();
    set_geometry(6'd1, 6'd2, 6'd1);
    run_random_items(180);
    set_geometry(6'd6, 6'd8, 6'd32);
    run_random_items(180);
    set_geometry(6'd0, 6'd0, 6'd0);
    run_random_items(150);
    set_geometry(6'h3F, 6'h3F, 6'd63);
    run_random_items(60);
    set_geometry(6'h0E, 6'd9, 6'd33);
    run_random_items(120);
  endtask

  task automatic test_random_mix();
    set_geometry(6'd3, 6'd4, 6'd6);
    write_cfg(CFG_UNUSED, '1);
    run_random_items(200);
    set_geometry(6'd2, 6'd3, 6'd12);
    run_random_items(200);
    set_geometry(6'd5, 6'd6, 6'd20);
    run_random_items(120);
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_SET_BITS;
    cfg_wdata      = '0;
    in_bus.valid   = 1'b0;
    in_bus.opcode  = OP_LOAD;
    in_bus.address = '0;
    out_bus.ready  = 1'b0;
    hit_cnt        = '0;
    miss_cnt       = '0;
    evict_cnt      = '0;
    for (int s = 0; s < MAX_SETS; s++) begin
      for (int w = 0; w < MAX_WAYS; w++) begin
        line_valid[s][w] = 1'b0;
        line_tag[s][w]   = '0;
        line_rank[s][w]  = '0;
      end
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_way_resize();
    test_geometry_extremes();
    test_random_mix();

    wait_results_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
